/* hdl/mprn_pkg.sv */
// Shared types and codes for the multiprotocol reachability attribute parser.
`timescale 1ns / 1ps

package mprn_pkg;

	localparam logic [1:0] KIND_NEXT_HOP = 2'd0;
	localparam logic [1:0] KIND_PREFIX   = 2'd1;
	localparam logic [1:0] KIND_ERROR    = 2'd2;

	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_HDR_SHORT   = 3'd1;
	localparam logic [2:0] ERR_FAMILY      = 3'd2;
	localparam logic [2:0] ERR_TRUNCATED   = 3'd3;
	localparam logic [2:0] ERR_BAD_LENGTH  = 3'd4;

	localparam logic [15:0] AFI_IPV4 = 16'd1;
	localparam logic [15:0] AFI_IPV6 = 16'd2;
	localparam logic [7:0]  SAFI_UNICAST = 8'd1;
	localparam logic [7:0]  SAFI_LABELED = 8'd4;
	localparam logic [7:0]  SAFI_VPN     = 8'd128;

	localparam int ADDR_W  = 128;
	localparam int LABEL_W = 24;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  error_code;
		logic [15:0] afi;
		logic [7:0]  safi;
		logic [7:0]  length_bits;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [23:0] top_label;
		logic [3:0]  label_count;
		logic        done_res;
	} route_t;

endpackage

/* hdl/mprn_attr_if.sv */
// Channel that carries attribute bytes into the parser.
`timescale 1ns / 1ps

interface mprn_attr_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       last_byte;

	modport source (output valid, output byte_in, output last_byte, input ready);
	modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

/* hdl/mprn_route_if.sv */
// Channel that carries parsed next-hop, prefix and error items out of the parser.
`timescale 1ns / 1ps

interface mprn_route_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  error_code;
	logic [15:0] afi;
	logic [7:0]  safi;
	logic [7:0]  length_bits;
	logic [63:0] addr_hi;
	logic [63:0] addr_lo;
	logic [23:0] top_label;
	logic [3:0]  label_count;
	logic        done_res;

	modport source (output valid, output kind, output error_code, output afi, output safi,
		output length_bits, output addr_hi, output addr_lo, output top_label,
		output label_count, output done_res, input ready);
	modport sink (input valid, input kind, input error_code, input afi, input safi,
		input length_bits, input addr_hi, input addr_lo, input top_label,
		input label_count, input done_res, output ready);
endinterface

/* hdl/bgp_mp_reach_nlri_parser_top.sv */
// Top level of the multiprotocol reachability attribute parser with its two-entry result queue.
//
// Channel  Direction  Item
// attr     in         one attribute byte with its end-of-attribute mark
// route    out        one next-hop, prefix or error record
//
// Each byte is parsed in the cycle it is accepted; one byte per cycle is sustained while the queue has room.
// A result is written into the queue when its byte is accepted, and the route channel is driven from the queue.
// Results wait in a two-entry queue, so bytes keep flowing while one result is stalled.
// The attr channel stalls only when both queue entries are full.
// Reset clears the parse state and empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps

module bgp_mp_reach_nlri_parser_top #(
	parameter int MAX_ADDR_BYTES = 16,
	parameter int MAX_LABELS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mprn_attr_if.sink            attr,
	mprn_route_if.source         route
);

	localparam int AW = MAX_ADDR_BYTES * 8;
	localparam int PAD = mprn_pkg::ADDR_W - AW;
	localparam logic [8:0] CAP_BITS = 9'(MAX_ADDR_BYTES * 8);
	localparam logic [7:0] KEEP_MAX = 8'(MAX_ADDR_BYTES);
	localparam logic [3:0] LABEL_MAX = 4'(MAX_LABELS);

	localparam logic [3:0] PH_AFI_HI = 4'd0;
	localparam logic [3:0] PH_AFI_LO = 4'd1;
	localparam logic [3:0] PH_SAFI   = 4'd2;
	localparam logic [3:0] PH_NHLEN  = 4'd3;
	localparam logic [3:0] PH_NH     = 4'd4;
	localparam logic [3:0] PH_RSVD   = 4'd5;
	localparam logic [3:0] PH_ELEN   = 4'd6;
	localparam logic [3:0] PH_LABEL  = 4'd7;
	localparam logic [3:0] PH_PREFIX = 4'd8;
	localparam logic [3:0] PH_DRAIN  = 4'd9;

	logic [3:0]    phase_q, n_phase;
	logic [7:0]    bc_q, n_bc;
	logic [15:0]   fam_q, n_fam;
	logic [7:0]    sub_q, n_sub;
	logic [7:0]    hop_q, n_hop;
	logic [AW-1:0] acc_q, n_acc, acc_put;
	logic [7:0]    eb_q, n_eb;
	logic [23:0]   lacc_q, n_lacc;
	logic [23:0]   flab_q, n_flab;
	logic [3:0]    ls_q, n_ls;

	logic          accept;
	logic          last;
	logic [7:0]    b;
	logic [7:0]    skip;
	logic [7:0]    put_pos;
	logic [7:0]    bc_inc;
	logic [3:0]    ls_inc;
	logic [7:0]    kept;
	logic [8:0]    lim;
	logic          fam_ok;
	logic          labeled;
	logic          do_body;
	logic          err_hit;
	logic [2:0]    err_code;
	logic          pfx_hit;
	logic          nh_hit;
	logic          has_res;
	logic [AW-1:0] res_src;
	logic [mprn_pkg::ADDR_W-1:0] res_addr;
	mprn_pkg::route_t res;

	mprn_pkg::route_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	assign b = attr.byte_in;
	assign last = attr.last_byte;
	assign attr.ready = (cnt_q != 2'd2);
	assign accept = attr.valid && attr.ready;

	assign skip = (fam_q == mprn_pkg::AFI_IPV4 && sub_q == mprn_pkg::SAFI_VPN) ? 8'd8 : 8'd0;
	assign put_pos = (phase_q == PH_NH) ? 8'(bc_q - skip) : bc_q;
	assign fam_ok = (fam_q == mprn_pkg::AFI_IPV4 || fam_q == mprn_pkg::AFI_IPV6) &&
		(sub_q == mprn_pkg::SAFI_UNICAST || sub_q == mprn_pkg::SAFI_LABELED ||
		sub_q == mprn_pkg::SAFI_VPN);
	assign labeled = (sub_q == mprn_pkg::SAFI_LABELED) || (sub_q == mprn_pkg::SAFI_VPN);

	always_comb begin
		logic [8:0] raw;
		raw = (fam_q == mprn_pkg::AFI_IPV4) ? 9'd32 : 9'd128;
		if (sub_q == mprn_pkg::SAFI_VPN) begin
			raw = raw + 9'd64;
		end
		lim = (raw > CAP_BITS) ? CAP_BITS : raw;
	end

	always_comb begin
		acc_put = acc_q;
		for (int i = 0; i < MAX_ADDR_BYTES; i++) begin
			if (put_pos == 8'(i)) begin
				acc_put[AW-1-8*i -: 8] = acc_q[AW-1-8*i -: 8] | b;
			end
		end
	end

	always_comb begin
		n_phase = phase_q;
		n_bc = bc_q;
		n_fam = fam_q;
		n_sub = sub_q;
		n_hop = hop_q;
		n_acc = acc_q;
		n_eb = eb_q;
		n_lacc = lacc_q;
		n_flab = flab_q;
		n_ls = ls_q;
		do_body = 1'b0;
		err_hit = 1'b0;
		err_code = mprn_pkg::ERR_NONE;
		pfx_hit = 1'b0;
		nh_hit = 1'b0;
		kept = 8'd0;
		bc_inc = 8'(bc_q + 8'd1);
		ls_inc = 4'(ls_q + 4'd1);
		res_src = acc_q;

		case (phase_q)
			PH_AFI_HI: begin
				n_fam = {b, 8'd0};
				n_phase = PH_AFI_LO;
			end
			PH_AFI_LO: begin
				n_fam = {fam_q[15:8], b};
				n_phase = PH_SAFI;
			end
			PH_SAFI: begin
				n_sub = b;
				n_phase = PH_NHLEN;
			end
			PH_NHLEN: begin
				n_hop = b;
				n_bc = 8'd0;
				n_acc = '0;
				n_phase = (b != 8'd0) ? PH_NH : PH_RSVD;
			end
			PH_NH: begin
				if (bc_q >= skip) begin
					n_acc = acc_put;
				end
				n_bc = bc_inc;
				if (bc_inc >= hop_q) begin
					n_phase = PH_RSVD;
				end
			end
			PH_RSVD: begin
				if (!fam_ok) begin
					err_hit = 1'b1;
					err_code = mprn_pkg::ERR_FAMILY;
				end else begin
					kept = (hop_q > skip) ? 8'(hop_q - skip) : 8'd0;
					if (kept > KEEP_MAX) begin
						kept = KEEP_MAX;
					end
					nh_hit = 1'b1;
					res_src = acc_q;
					n_acc = '0;
					n_phase = PH_ELEN;
				end
			end
			PH_ELEN: begin
				n_eb = b;
				n_ls = 4'd0;
				n_flab = 24'd0;
				n_lacc = 24'd0;
				n_bc = 8'd0;
				n_acc = '0;
				if (labeled) begin
					if (b < 8'd24) begin
						err_hit = 1'b1;
						err_code = mprn_pkg::ERR_BAD_LENGTH;
					end else begin
						n_phase = PH_LABEL;
					end
				end else begin
					do_body = 1'b1;
				end
			end
			PH_LABEL: begin
				n_lacc = {lacc_q[15:0], b};
				if (bc_inc >= 8'd3) begin
					n_bc = 8'd0;
					n_ls = ls_inc;
					if (ls_inc == 4'd1) begin
						n_flab = n_lacc;
					end
					n_eb = 8'(eb_q - 8'd24);
					if (n_lacc[0]) begin
						do_body = 1'b1;
					end else if (ls_inc >= LABEL_MAX || n_eb < 8'd24) begin
						err_hit = 1'b1;
						err_code = mprn_pkg::ERR_BAD_LENGTH;
					end
				end else begin
					n_bc = bc_inc;
				end
			end
			PH_PREFIX: begin
				n_acc = acc_put;
				n_bc = bc_inc;
				if (bc_inc >= 8'((({1'b0, eb_q} + 9'd7) >> 3))) begin
					pfx_hit = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (do_body) begin
			if ({1'b0, n_eb} > lim) begin
				err_hit = 1'b1;
				err_code = mprn_pkg::ERR_BAD_LENGTH;
			end else begin
				n_bc = 8'd0;
				if (n_eb == 8'd0) begin
					pfx_hit = 1'b1;
				end else begin
					n_phase = PH_PREFIX;
				end
			end
		end

		if (pfx_hit) begin
			res_src = n_acc;
			n_acc = '0;
			n_phase = PH_ELEN;
		end
		if (err_hit) begin
			n_phase = PH_DRAIN;
		end

		if (last && !(err_hit || pfx_hit || nh_hit)) begin
			if (phase_q <= PH_NH) begin
				err_hit = 1'b1;
				err_code = mprn_pkg::ERR_HDR_SHORT;
			end else if (phase_q >= PH_ELEN && phase_q <= PH_PREFIX && n_phase != PH_ELEN) begin
				err_hit = 1'b1;
				err_code = mprn_pkg::ERR_TRUNCATED;
			end
		end

		res_addr = mprn_pkg::ADDR_W'(res_src) << PAD;
		res.kind = err_hit ? mprn_pkg::KIND_ERROR :
			(nh_hit ? mprn_pkg::KIND_NEXT_HOP : mprn_pkg::KIND_PREFIX);
		res.error_code = err_hit ? err_code : mprn_pkg::ERR_NONE;
		res.afi = n_fam;
		res.safi = n_sub;
		res.length_bits = err_hit ? 8'd0 : (nh_hit ? 8'({kept, 3'b000}) : n_eb);
		res.addr_hi = err_hit ? 64'd0 : res_addr[127:64];
		res.addr_lo = err_hit ? 64'd0 : res_addr[63:0];
		res.top_label = (err_hit || nh_hit) ? 24'd0 : n_flab;
		res.label_count = (err_hit || nh_hit) ? 4'd0 : n_ls;
		res.done_res = last;
		has_res = err_hit || pfx_hit || nh_hit;

		if (last) begin
			n_phase = PH_AFI_HI;
			n_bc = 8'd0;
			n_fam = 16'd0;
			n_sub = 8'd0;
			n_hop = 8'd0;
			n_acc = '0;
			n_eb = 8'd0;
			n_lacc = 24'd0;
			n_flab = 24'd0;
			n_ls = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_AFI_HI;
			bc_q <= 8'd0;
			fam_q <= 16'd0;
			sub_q <= 8'd0;
			hop_q <= 8'd0;
			acc_q <= '0;
			eb_q <= 8'd0;
			lacc_q <= 24'd0;
			flab_q <= 24'd0;
			ls_q <= 4'd0;
		end else if (accept) begin
			phase_q <= n_phase;
			bc_q <= n_bc;
			fam_q <= n_fam;
			sub_q <= n_sub;
			hop_q <= n_hop;
			acc_q <= n_acc;
			eb_q <= n_eb;
			lacc_q <= n_lacc;
			flab_q <= n_flab;
			ls_q <= n_ls;
		end
	end

	// Two-entry result queue between the parser and the route channel.
	assign push = accept && has_res;
	assign pop = route.valid && route.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= res;
		end
	end

	assign route.valid = (cnt_q != 2'd0);
	assign route.kind = slot_q[rd_ptr_q].kind;
	assign route.error_code = slot_q[rd_ptr_q].error_code;
	assign route.afi = slot_q[rd_ptr_q].afi;
	assign route.safi = slot_q[rd_ptr_q].safi;
	assign route.length_bits = slot_q[rd_ptr_q].length_bits;
	assign route.addr_hi = slot_q[rd_ptr_q].addr_hi;
	assign route.addr_lo = slot_q[rd_ptr_q].addr_lo;
	assign route.top_label = slot_q[rd_ptr_q].top_label;
	assign route.label_count = slot_q[rd_ptr_q].label_count;
	assign route.done_res = slot_q[rd_ptr_q].done_res;

endmodule

/* hdl/mprn_checker.sv */
// Port-level checks for the multiprotocol reachability attribute parser, bound to its top level.
`timescale 1ns / 1ps

module mprn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        route_valid,
	input logic        route_ready,
	input logic [1:0]  kind,
	input logic [2:0]  error_code,
	input logic [7:0]  length_bits,
	input logic [63:0] addr_hi,
	input logic [63:0] addr_lo,
	input logic [23:0] top_label,
	input logic [3:0]  label_count
);

	// The result queue is empty while reset is applied.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !route_valid)
		else $error("route item offered during reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		route_valid && !route_ready |=> route_valid && $stable(kind) && $stable(addr_hi) &&
		$stable(addr_lo) && $stable(length_bits))
		else $error("stalled route item changed");

	a_code_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		route_valid |-> ((kind == mprn_pkg::KIND_ERROR) == (error_code != mprn_pkg::ERR_NONE)))
		else $error("error code disagrees with item kind");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		route_valid && kind == mprn_pkg::KIND_ERROR |-> length_bits == 8'd0 &&
		addr_hi == 64'd0 && addr_lo == 64'd0 && top_label == 24'd0 && label_count == 4'd0)
		else $error("error item carries route data");

	a_next_hop_unlabeled: assert property (@(posedge clk) disable iff (!arst_n)
		route_valid && kind == mprn_pkg::KIND_NEXT_HOP |-> top_label == 24'd0 &&
		label_count == 4'd0 && length_bits[2:0] == 3'd0)
		else $error("next-hop item carries labels or a partial byte");

endmodule

bind bgp_mp_reach_nlri_parser_top mprn_checker u_mprn_checker (
	.clk(clk),
	.arst_n(arst_n),
	.route_valid(route.valid),
	.route_ready(route.ready),
	.kind(route.kind),
	.error_code(route.error_code),
	.length_bits(route.length_bits),
	.addr_hi(route.addr_hi),
	.addr_lo(route.addr_lo),
	.top_label(route.top_label),
	.label_count(route.label_count)
);
